FILE: rtl/core/rect_fill_ink_blender_macros.svh
// ----------------------------------------------------------------------------
// rect_fill_ink_blender assertion macros
// concurrent checks on clk, switched off with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef RECT_FILL_INK_BLENDER_MACROS_SVH
`define RECT_FILL_INK_BLENDER_MACROS_SVH
`ifndef ASSERT_OFF
// condition must never hold
`define RFIB_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
// antecedent implies consequent in the next cycle
`define RFIB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RFIB_ASSERT_NEVER(lbl, expr, msg)
`define RFIB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rfib_pkg.sv
// ----------------------------------------------------------------------------
// rfib_pkg
// shared types, codes and ink arithmetic of the rectangle fill blender
// ----------------------------------------------------------------------------
package rfib_pkg;

	localparam int FRAME_WIDTH_DEF  = 512;
	localparam int FRAME_HEIGHT_DEF = 256;
	localparam int SW               = 35;   // width of signed setup arithmetic
	localparam int LUT_DEPTH        = 65536;

	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_WR_PIX = 2'd1,
		ACT_RD_PIX = 2'd2,
		ACT_WR_LUT = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_BLEND   = 3'd1,
		MODE_ALPHA   = 3'd2,
		MODE_ADD     = 3'd3,
		MODE_SUB     = 3'd4,
		MODE_RECOL   = 3'd5,
		MODE_KEYED   = 3'd6,
		MODE_UNKEYED = 3'd7
	} ink_t;

	typedef enum logic [2:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_RIGHT  = 3'd1,
		REG_CLIP_TOP    = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_CAMERA_X    = 3'd4,
		REG_CAMERA_Y    = 3'd5,
		REG_MASK_COLOUR = 3'd6,
		REG_LOOKUP_EN   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic signed [31:0] rect_width;
		logic signed [31:0] rect_height;
		logic [23:0]        colour_rgb;
		logic [8:0]         alpha;
		logic [2:0]         ink_mode;
		logic               screen_relative;
		logic [15:0]        pixel_data;
		logic [15:0]        table_index;
	} item_t;

	typedef struct packed {
		logic clear;    // clearing pass, one pixel
		logic load;     // latch item and convert coordinates
		logic clip_r;   // right and bottom clip
		logic clip_l;   // left and top clip
		logic setup;    // decide draw, load walk counters
		logic step;     // issue one pixel of the walk
		logic pix;      // single pixel or table access
		logic res;      // capture result
	} ctrl_cmd_t;

	typedef struct packed {
		logic go;
		logic last_pixel;
		logic pipe_busy;
		logic clear_last;
	} ctrl_stat_t;

	function automatic logic [4:0] wgt(input logic [7:0] a, input logic [4:0] c);
		logic [12:0] p;
		p = 13'(a) * 13'(c);
		return p[12:8];
	endfunction

	function automatic logic [15:0] rgb_to_565(input logic [23:0] rgb);
		return {rgb[23:19], rgb[15:10], rgb[7:3]};
	endfunction

	function automatic logic [15:0] px_alpha(input logic [15:0] d, input logic [15:0] c,
			input logic [7:0] a);
		logic [7:0]  ia;
		logic [5:0]  b6, g6, r6;
		logic [16:0] o;
		ia = 8'hFF - a;
		b6 = {1'b0, wgt(ia, d[4:0])} + {1'b0, wgt(a, c[4:0])};
		g6 = {1'b0, wgt(ia, d[10:6])} + {1'b0, wgt(a, c[10:6])};
		r6 = {1'b0, wgt(ia, d[15:11])} + {1'b0, wgt(a, c[15:11])};
		o  = 17'(b6) | (17'(g6) << 6) | (17'(r6) << 11);
		return o[15:0];
	endfunction

	function automatic logic [15:0] px_add(input logic [15:0] d, input logic [15:0] c,
			input logic [7:0] a);
		logic [5:0]  rs, bs;
		logic [4:0]  r5, b5;
		logic [11:0] gv;
		rs = {1'b0, wgt(a, c[15:11])} + {1'b0, d[15:11]};
		r5 = (rs > 6'd31) ? 5'd31 : rs[4:0];
		gv = {1'b0, wgt(a, c[10:6]), 6'b0} + {1'b0, d[10:5], 5'b0};
		if (gv > 12'h7E0) gv = 12'h7E0;
		bs = {1'b0, wgt(a, c[4:0])} + {1'b0, d[4:0]};
		b5 = (bs > 6'd31) ? 5'd31 : bs[4:0];
		return {r5, 11'b0} | {4'b0, gv} | {11'b0, b5};
	endfunction

	function automatic logic [15:0] px_sub(input logic [15:0] d, input logic [15:0] c,
			input logic [7:0] a);
		logic signed [6:0]  rdiff, bdiff;
		logic signed [12:0] gdiff;
		logic [15:0]        o;
		rdiff = 7'(d[15:11]) - 7'(wgt(a, c[15:11]));
		gdiff = 13'({d[10:5], 5'b0}) - 13'({wgt(a, c[10:6]), 6'b0});
		bdiff = 7'(d[4:0]) - 7'(wgt(a, c[4:0]));
		o = '0;
		if (rdiff > 0) o = o | {rdiff[4:0], 11'b0};
		if (gdiff > 0) o = o | 16'(gdiff[11:0]);
		if (bdiff > 0) o = o | 16'(bdiff[4:0]);
		return o;
	endfunction

endpackage

FILE: rtl/core/rfib_if.sv
// ----------------------------------------------------------------------------
// rfib channel interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface rfib_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic signed [31:0] rect_width;
	logic signed [31:0] rect_height;
	logic [23:0]        colour_rgb;
	logic [8:0]         alpha;
	logic [2:0]         ink_mode;
	logic               screen_relative;
	logic [15:0]        pixel_data;
	logic [15:0]        table_index;

	modport source (output valid, action, x_pos, y_pos, rect_width, rect_height,
		colour_rgb, alpha, ink_mode, screen_relative, pixel_data, table_index,
		input ready);
	modport sink (input valid, action, x_pos, y_pos, rect_width, rect_height,
		colour_rgb, alpha, ink_mode, screen_relative, pixel_data, table_index,
		output ready);
endinterface

interface rfib_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        drew_pixels;

	modport source (output valid, read_data, drew_pixels, input ready);
	modport sink (input valid, read_data, drew_pixels, output ready);
endinterface

FILE: rtl/core/rect_fill_ink_blender.sv
// ----------------------------------------------------------------------------
// rect_fill_ink_blender
// RGB565 rectangle fill engine with eight inks and a recolour table
// ----------------------------------------------------------------------------
// After reset the block clears its frame store, one pixel a cycle; commands
// are held off until then, configuration writes are taken throughout. One
// command is worked at a time. Pixel writes, pixel reads and recolour table
// writes go through the item latch, the access step and the result post. A
// draw goes through setup (item latch with coordinate conversion, right and
// bottom clip, left and top clip, walk setup), then walks the covered pixels
// one a cycle, waits for the read-modify-write pipeline to drain and posts
// the result; a draw that covers no pixel goes from walk setup straight to
// the result. The single read and single write port of the frame store set
// the one pixel a cycle walk. The result sits in an output register, so the
// next command is taken while a result still waits to be taken.
// ----------------------------------------------------------------------------
`include "rect_fill_ink_blender_macros.svh"

module rect_fill_ink_blender import rfib_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	rfib_cmd_if.sink    cmd_ch,
	rfib_res_if.source  res_ch
);

	// command payload gathered into one struct for the datapath
	item_t      item;
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign item = '{
		action:          cmd_ch.action,
		x_pos:           cmd_ch.x_pos,
		y_pos:           cmd_ch.y_pos,
		rect_width:      cmd_ch.rect_width,
		rect_height:     cmd_ch.rect_height,
		colour_rgb:      cmd_ch.colour_rgb,
		alpha:           cmd_ch.alpha,
		ink_mode:        cmd_ch.ink_mode,
		screen_relative: cmd_ch.screen_relative,
		pixel_data:      cmd_ch.pixel_data,
		table_index:     cmd_ch.table_index
	};

	// sequencer: clearing pass, setup steps, pixel walk, result hand-off
	rfib_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_ch.valid),
		.in_action (cmd_ch.action),
		.in_ready  (cmd_ch.ready),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// registers, clip arithmetic, ink pipeline, frame store and recolour table
	rfib_datapath #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.item        (item),
		.cmd         (cmd),
		.stat        (stat),
		.read_data   (res_ch.read_data),
		.drew_pixels (res_ch.drew_pixels)
	);

	// one command in flight: a transfer is never followed by another at once
	`RFIB_ASSERT_NEXT(a_one_in_flight, cmd.load, !cmd_ch.ready, "command taken while busy")
	// the clearing pass never overlaps pipeline writes
	`RFIB_ASSERT_NEVER(a_clear_quiet, cmd.clear && stat.pipe_busy, "clear during draw")
	// a result is only posted once the pipeline has drained
	`RFIB_ASSERT_NEVER(a_res_drained, cmd.res && stat.pipe_busy, "result before drain")

endmodule

FILE: rtl/core/rfib_datapath.sv
// ----------------------------------------------------------------------------
// rfib_datapath
// registers, clipping arithmetic, pixel walk, ink pipeline and memories
// ----------------------------------------------------------------------------
module rfib_datapath import rfib_pkg::*; #(
	parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	input  item_t       item,
	input  ctrl_cmd_t   cmd,
	output ctrl_stat_t  stat,
	output logic [15:0] read_data,
	output logic        drew_pixels
);

	localparam int FRAME_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int CW = $clog2(FRAME_WIDTH);
	localparam int RW = $clog2(FRAME_HEIGHT);

	// configuration
	logic [8:0]         clip_left_q;
	logic [9:0]         clip_right_q;
	logic [7:0]         clip_top_q;
	logic [8:0]         clip_bottom_q;
	logic signed [15:0] camera_x_q, camera_y_q;
	logic [15:0]        mask_colour_q;
	logic               lookup_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= 9'd0;
			clip_right_q  <= 10'd424;
			clip_top_q    <= 8'd0;
			clip_bottom_q <= 9'd240;
			camera_x_q    <= '0;
			camera_y_q    <= '0;
			mask_colour_q <= '0;
			lookup_en_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CLIP_LEFT:   clip_left_q   <= wr_data[8:0];
				REG_CLIP_RIGHT:  clip_right_q  <= wr_data[9:0];
				REG_CLIP_TOP:    clip_top_q    <= wr_data[7:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= wr_data[8:0];
				REG_CAMERA_X:    camera_x_q    <= wr_data;
				REG_CAMERA_Y:    camera_y_q    <= wr_data;
				REG_MASK_COLOUR: mask_colour_q <= wr_data;
				REG_LOOKUP_EN:   lookup_en_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// item and draw setup
	item_t              item_q;
	logic signed [SW-1:0] x_q, y_q, w_q, h_q;
	ink_t               ink_q;
	logic [7:0]         a_q;
	logic [15:0]        c_q;
	logic               skip_q, go_q;
	logic signed [SW-1:0] rlim, blim, cl, ct;
	ink_t               ink_in;

	assign ink_in = ink_t'(item.ink_mode);
	assign rlim = (SW'(clip_right_q) < SW'(FRAME_WIDTH)) ? SW'(clip_right_q) : SW'(FRAME_WIDTH);
	assign blim = (SW'(clip_bottom_q) < SW'(FRAME_HEIGHT)) ?
		SW'(clip_bottom_q) : SW'(FRAME_HEIGHT);
	assign cl = SW'(clip_left_q);
	assign ct = SW'(clip_top_q);
	assign stat.go = !skip_q && (w_q > 0) && (h_q > 0);

	// walk counters
	logic [CW-1:0] col_q, x_first_q, x_last_q;
	logic [RW-1:0] row_q, y_last_q;
	logic [AW-1:0] addr_q, row_base_q, start_addr;

	assign start_addr = AW'(y_q[RW-1:0]) * AW'(FRAME_WIDTH) + AW'(x_q[CW-1:0]);
	assign stat.last_pixel = (col_q == x_last_q) && (row_q == y_last_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			c_q    <= rgb_to_565(item.colour_rgb);
			a_q    <= (item.alpha > 9'd255) ? 8'hFF : item.alpha[7:0];
			ink_q  <= (ink_in == MODE_ALPHA && item.alpha > 9'd255) ? MODE_PLAIN : ink_in;
			case (ink_in) inside
				MODE_ALPHA, MODE_ADD, MODE_SUB: skip_q <= (item.alpha == 9'd0);
				MODE_RECOL:                     skip_q <= !lookup_en_q;
				default:                        skip_q <= 1'b0;
			endcase
			if (item.screen_relative) begin
				x_q <= SW'(item.x_pos);
				y_q <= SW'(item.y_pos);
				w_q <= SW'(item.rect_width);
				h_q <= SW'(item.rect_height);
			end else begin
				x_q <= SW'($signed(item.x_pos[31:16])) - SW'(camera_x_q);
				y_q <= SW'($signed(item.y_pos[31:16])) - SW'(camera_y_q);
				w_q <= SW'($signed(item.rect_width[31:16]));
				h_q <= SW'($signed(item.rect_height[31:16]));
			end
		end
		if (cmd.clip_r) begin
			if (w_q + x_q > rlim) w_q <= rlim - x_q;
			if (h_q + y_q > blim) h_q <= blim - y_q;
		end
		if (cmd.clip_l) begin
			if (x_q < cl) begin
				w_q <= w_q + (x_q - cl);
				x_q <= cl;
			end
			if (y_q < ct) begin
				h_q <= h_q + (y_q - ct);
				y_q <= ct;
			end
		end
		if (cmd.setup) begin
			col_q      <= x_q[CW-1:0];
			x_first_q  <= x_q[CW-1:0];
			x_last_q   <= CW'(x_q + w_q - SW'(1));
			row_q      <= y_q[RW-1:0];
			y_last_q   <= RW'(y_q + h_q - SW'(1));
			addr_q     <= start_addr;
			row_base_q <= start_addr;
		end
		if (cmd.step) begin
			if (col_q == x_last_q) begin
				col_q      <= x_first_q;
				row_q      <= row_q + RW'(1);
				row_base_q <= row_base_q + AW'(FRAME_WIDTH);
				addr_q     <= row_base_q + AW'(FRAME_WIDTH);
			end else begin
				col_q  <= col_q + CW'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else if (cmd.load) begin
			go_q <= 1'b0;
		end else if (cmd.setup) begin
			go_q <= stat.go;
		end
	end

	// single pixel access
	logic          in_frame;
	logic [AW-1:0] pix_addr;

	assign in_frame = (item_q.x_pos >= 0) && (item_q.x_pos < 32'(FRAME_WIDTH)) &&
		(item_q.y_pos >= 0) && (item_q.y_pos < 32'(FRAME_HEIGHT));
	assign pix_addr = AW'(item_q.y_pos[RW-1:0]) * AW'(FRAME_WIDTH) +
		AW'(item_q.x_pos[CW-1:0]);

	// clearing pass counter
	logic [AW-1:0] clr_q;

	assign stat.clear_last = (clr_q == AW'(FRAME_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// ink pipeline: s1 holds frame read data, s2 holds the value to write
	logic          valid_s1, valid_s2;
	logic [AW-1:0] addr_s1, addr_s2;
	logic [15:0]   val_s2, fr_rd_q, lut_rd_q, new_px;

	assign stat.pipe_busy = valid_s1 | valid_s2;

	always_comb begin
		case (ink_q)
			MODE_ALPHA:   new_px = px_alpha(fr_rd_q, c_q, a_q);
			MODE_ADD:     new_px = px_add(fr_rd_q, c_q, a_q);
			MODE_SUB:     new_px = px_sub(fr_rd_q, c_q, a_q);
			MODE_KEYED:   new_px = (fr_rd_q == mask_colour_q) ? c_q : fr_rd_q;
			MODE_UNKEYED: new_px = (fr_rd_q != mask_colour_q) ? c_q : fr_rd_q;
			default:      new_px = c_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		addr_s2 <= addr_s1;
		val_s2  <= new_px;
	end

	// frame store port selection
	logic          fr_we, fr_re, lut_we, lut_re;
	logic [AW-1:0] fr_waddr, fr_raddr;
	logic [15:0]   fr_wdata;

	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = pix_addr;
		fr_wdata = item_q.pixel_data;
		if (cmd.clear) begin
			fr_we    = 1'b1;
			fr_waddr = clr_q;
			fr_wdata = '0;
		end else if (valid_s2) begin
			fr_we    = 1'b1;
			fr_waddr = addr_s2;
			fr_wdata = (ink_q == MODE_RECOL) ? lut_rd_q : val_s2;
		end else if (cmd.pix && action_t'(item_q.action) == ACT_WR_PIX && in_frame) begin
			fr_we = 1'b1;
		end
	end

	assign fr_re    = cmd.step | (cmd.pix && action_t'(item_q.action) == ACT_RD_PIX);
	assign fr_raddr = cmd.step ? addr_q : pix_addr;
	assign lut_we   = cmd.pix && action_t'(item_q.action) == ACT_WR_LUT;
	assign lut_re   = valid_s1 && ink_q == MODE_RECOL;

	logic [15:0] frame_mem [FRAME_DEPTH];
	logic [15:0] lut_mem [LUT_DEPTH];

	always_ff @(posedge clk) begin
		if (fr_we) frame_mem[fr_waddr] <= fr_wdata;
		if (fr_re) fr_rd_q <= frame_mem[fr_raddr];
	end

	always_ff @(posedge clk) begin
		if (lut_we) lut_mem[item_q.table_index] <= item_q.pixel_data;
		if (lut_re) lut_rd_q <= lut_mem[fr_rd_q];
	end

	// result payload
	logic [15:0] read_data_q;
	logic        drew_q;

	always_ff @(posedge clk) begin
		if (cmd.res) begin
			read_data_q <= (action_t'(item_q.action) == ACT_RD_PIX && in_frame) ? fr_rd_q : '0;
			drew_q      <= go_q;
		end
	end

	assign read_data   = read_data_q;
	assign drew_pixels = drew_q;

endmodule

FILE: rtl/core/rfib_controller.sv
// ----------------------------------------------------------------------------
// rfib_controller
// sequencer for clear, setup, pixel walk, drain and result hand-off
// ----------------------------------------------------------------------------
module rfib_controller import rfib_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_action,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_PIX   = 9'b000000100,
		ST_CLIPR = 9'b000001000,
		ST_CLIPL = 9'b000010000,
		ST_SETUP = 9'b000100000,
		ST_DRAW  = 9'b001000000,
		ST_DRAIN = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, res_free;

	assign res_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (action_t'(in_action) == ACT_DRAW) ? ST_CLIPR : ST_PIX;
				end
			end
			ST_PIX: begin
				cmd.pix = 1'b1;
				state_d = ST_RESP;
			end
			ST_CLIPR: begin
				cmd.clip_r = 1'b1;
				state_d    = ST_CLIPL;
			end
			ST_CLIPL: begin
				cmd.clip_l = 1'b1;
				state_d    = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = stat.go ? ST_DRAW : ST_RESP;
			end
			ST_DRAW: begin
				cmd.step = 1'b1;
				if (stat.last_pixel) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (res_free) begin
					cmd.res = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: verif/rect_fill_ink_blender_tb.sv
// ----------------------------------------------------------------------------
// rect_fill_ink_blender_tb
// self-checking bench: a directed table then random phases of draws, pixel
// and recolour table accesses, each result checked against its table row or a
// local model of frame store, recolour table, clip and camera registers
// ----------------------------------------------------------------------------
module rect_fill_ink_blender_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rfib_pkg::*;

	localparam int FW = 512;
	localparam int FH = 256;

	typedef struct {
		logic [15:0] rd;
		bit          drew;
	} outcome_t;

	typedef struct {
		item_t    it;
		bit       typed;   // expected result written in the row
		outcome_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	rfib_cmd_if cmd_ch();
	rfib_res_if res_ch();

	rect_fill_ink_blender u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd_ch   (cmd_ch),
		.res_ch   (res_ch)
	);

	// local copy of the block state
	logic [15:0]        pix_mem [0:FW*FH-1];
	logic [15:0]        recol_mem [0:65535];
	bit                 recol_known [0:65535];
	int                 cl_left, cl_right, cl_top, cl_bottom;
	logic signed [15:0] cam_x, cam_y;
	logic [15:0]        key_colour;
	bit                 recol_on;

	outcome_t pending_q [$];
	int       n_errors;
	int       n_sent;
	int       n_results;
	row_t     rows [$];

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int weigh(int a, int c);
		return (a * c) >> 8;
	endfunction

	function automatic logic [15:0] mix_alpha(int d, int c, int a);
		int ia, b, g, r;
		ia = 255 - a;
		b = weigh(ia, d & 'h1F) + weigh(a, c & 'h1F);
		g = weigh(ia, (d >> 6) & 'h1F) + weigh(a, (c >> 6) & 'h1F);
		r = weigh(ia, d >> 11) + weigh(a, c >> 11);
		return 16'(b | (g << 6) | (r << 11));
	endfunction

	function automatic logic [15:0] mix_add(int d, int c, int a);
		int r, g, b;
		r = (weigh(a, c >> 11) << 11) + (d & 'hF800);
		g = (weigh(a, (c >> 6) & 'h1F) << 6) + (d & 'h7E0);
		b = weigh(a, c & 'h1F) + (d & 'h1F);
		if (r > 'hF800) r = 'hF800;
		if (g > 'h7E0) g = 'h7E0;
		if (b > 'h1F) b = 'h1F;
		return 16'(r | g | b);
	endfunction

	function automatic logic [15:0] mix_sub(int d, int c, int a);
		int r, g, b, o;
		r = (d & 'hF800) - (weigh(a, c >> 11) << 11);
		g = (d & 'h7E0) - (weigh(a, (c >> 6) & 'h1F) << 6);
		b = (d & 'h1F) - weigh(a, c & 'h1F);
		o = 0;
		if (r > 0) o = o | r;
		if (g > 0) o = o | g;
		if (b > 0) o = o | b;
		return 16'(o);
	endfunction

	// world conversion and clipping, gives the covered box
	function automatic bit clip_box(item_t it, output longint bx, output longint by,
			output longint bw, output longint bh);
		longint rlim, blim;
		bx = longint'(it.x_pos);
		by = longint'(it.y_pos);
		bw = longint'(it.rect_width);
		bh = longint'(it.rect_height);
		if (!it.screen_relative) begin
			// arithmetic shift is the floor of a 16.16 value
			bx = (bx >>> 16) - longint'(cam_x);
			by = (by >>> 16) - longint'(cam_y);
			bw = bw >>> 16;
			bh = bh >>> 16;
		end
		rlim = (cl_right < FW) ? cl_right : FW;
		blim = (cl_bottom < FH) ? cl_bottom : FH;
		if (bw + bx > rlim) bw = rlim - bx;
		if (bx < cl_left) begin
			bw = bw + bx - cl_left;
			bx = cl_left;
		end
		if (bh + by > blim) bh = blim - by;
		if (by < cl_top) begin
			bh = bh + by - cl_top;
			by = cl_top;
		end
		return (bw > 0) && (bh > 0);
	endfunction

	function automatic bit fill_rect(item_t it);
		longint bx, by, bw, bh;
		int     a, d, c, p;
		ink_t   ink;
		ink = ink_t'(it.ink_mode);
		a = it.alpha;
		if (ink == MODE_ALPHA) begin
			if (a == 0) return 0;
			if (a > 255) ink = MODE_PLAIN;
		end else if (ink == MODE_ADD || ink == MODE_SUB) begin
			if (a == 0) return 0;
			if (a > 255) a = 255;
		end else if (ink == MODE_RECOL) begin
			if (!recol_on) return 0;
		end
		if (!clip_box(it, bx, by, bw, bh)) return 0;
		c = {it.colour_rgb[23:19], it.colour_rgb[15:10], it.colour_rgb[7:3]};
		for (longint j = by; j < by + bh; j++) begin
			for (longint i = bx; i < bx + bw; i++) begin
				p = int'(j * FW + i);
				d = pix_mem[p];
				case (ink)
					MODE_ALPHA:   pix_mem[p] = mix_alpha(d, c, a);
					MODE_ADD:     pix_mem[p] = mix_add(d, c, a);
					MODE_SUB:     pix_mem[p] = mix_sub(d, c, a);
					MODE_RECOL:   pix_mem[p] = recol_mem[d];
					MODE_KEYED:   if (d == key_colour) pix_mem[p] = 16'(c);
					MODE_UNKEYED: if (d != key_colour) pix_mem[p] = 16'(c);
					default:      pix_mem[p] = 16'(c);
				endcase
			end
		end
		return 1;
	endfunction

	// apply one accepted command to the local state, give its result
	function automatic outcome_t apply_cmd(item_t it);
		outcome_t o;
		longint   px, py;
		bit       in_frame;
		o.rd = '0;
		o.drew = 0;
		px = longint'(it.x_pos);
		py = longint'(it.y_pos);
		in_frame = px >= 0 && px < FW && py >= 0 && py < FH;
		case (action_t'(it.action))
			ACT_DRAW:   o.drew = fill_rect(it);
			ACT_WR_PIX: if (in_frame) pix_mem[py * FW + px] = it.pixel_data;
			ACT_RD_PIX: if (in_frame) o.rd = pix_mem[py * FW + px];
			default: begin
				recol_mem[it.table_index] = it.pixel_data;
				recol_known[it.table_index] = 1;
			end
		endcase
		return o;
	endfunction

	function automatic item_t mk(action_t act, int x, int y, int w, int h, int rgb,
			int a, ink_t ink, bit scr, int pd, int ti);
		item_t it;
		it.action = act;
		it.x_pos = x;
		it.y_pos = y;
		it.rect_width = w;
		it.rect_height = h;
		it.colour_rgb = 24'(rgb);
		it.alpha = 9'(a);
		it.ink_mode = ink;
		it.screen_relative = scr;
		it.pixel_data = 16'(pd);
		it.table_index = 16'(ti);
		return it;
	endfunction

	function automatic bit calm_sender();
		return n_sent >= 70 && n_sent < 95;
	endfunction

	// offer one command, wait for its transfer, record what it should give
	task automatic send(item_t it, bit typed = 0, outcome_t want = '{16'h0, 0});
		outcome_t o;
		if (!calm_sender() && $urandom_range(99) < 22) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd_ch.valid           <= 1'b1;
		cmd_ch.action          <= it.action;
		cmd_ch.x_pos           <= it.x_pos;
		cmd_ch.y_pos           <= it.y_pos;
		cmd_ch.rect_width      <= it.rect_width;
		cmd_ch.rect_height     <= it.rect_height;
		cmd_ch.colour_rgb      <= it.colour_rgb;
		cmd_ch.alpha           <= it.alpha;
		cmd_ch.ink_mode        <= it.ink_mode;
		cmd_ch.screen_relative <= it.screen_relative;
		cmd_ch.pixel_data      <= it.pixel_data;
		cmd_ch.table_index     <= it.table_index;
		do @(posedge clk); while (!cmd_ch.ready);
		n_sent++;
		o = apply_cmd(it);
		pending_q.push_back(typed ? want : o);
	endtask

	// register write, only once every result is home
	task automatic set_reg(reg_idx_t r, int v);
		cmd_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= r;
		wr_data  <= 16'(v);
		@(posedge clk);
		wr_en <= 1'b0;
		case (r)
			REG_CLIP_LEFT:   cl_left = v & 'h1FF;
			REG_CLIP_RIGHT:  cl_right = v & 'h3FF;
			REG_CLIP_TOP:    cl_top = v & 'hFF;
			REG_CLIP_BOTTOM: cl_bottom = v & 'h1FF;
			REG_CAMERA_X:    cam_x = 16'(v);
			REG_CAMERA_Y:    cam_y = 16'(v);
			REG_MASK_COLOUR: key_colour = 16'(v);
			default:         recol_on = v[0];
		endcase
	endtask

	task automatic set_all(int l, int r, int t, int b, int cx, int cy, int mk_c, int en);
		set_reg(REG_CLIP_LEFT, l);
		set_reg(REG_CLIP_RIGHT, r);
		set_reg(REG_CLIP_TOP, t);
		set_reg(REG_CLIP_BOTTOM, b);
		set_reg(REG_CAMERA_X, cx);
		set_reg(REG_CAMERA_Y, cy);
		set_reg(REG_MASK_COLOUR, mk_c);
		set_reg(REG_LOOKUP_EN, en);
	endtask

	// a lookup draw may only meet recolour entries already written
	task automatic fill_recol_gaps(item_t it);
		longint bx, by, bw, bh;
		int     d;
		if (!recol_on || !clip_box(it, bx, by, bw, bh)) return;
		for (longint j = by; j < by + bh; j++) begin
			for (longint i = bx; i < bx + bw; i++) begin
				d = pix_mem[j * FW + i];
				if (!recol_known[d])
					send(mk(ACT_WR_LUT, 0, 0, 0, 0, 0, 0, MODE_PLAIN, 1, $urandom, d));
			end
		end
	endtask

	function automatic item_t rand_cmd();
		item_t   it;
		int      sx, sy, pick;
		longint  wx, wy;
		it = mk(ACT_DRAW, 0, 0, 0, 0, $urandom, $urandom_range(511),
			ink_t'($urandom_range(7)), $urandom_range(99) < 65, $urandom, $urandom);
		pick = $urandom_range(99);
		if (pick < 60) begin
			sx = $urandom_range(540) - 20;
			sy = $urandom_range(280) - 20;
			it.rect_width = $urandom_range(16) - 2;
			it.rect_height = $urandom_range(10) - 2;
			if (it.screen_relative) begin
				it.x_pos = sx;
				it.y_pos = sy;
			end else begin
				// world units with a random fraction
				wx = (longint'(sx) + cam_x) * 65536 + $urandom_range(65535);
				wy = (longint'(sy) + cam_y) * 65536 + $urandom_range(65535);
				it.x_pos = (wx > 64'sh7FFFFFFF || wx < -64'sh80000000) ? $urandom : 32'(wx);
				it.y_pos = (wy > 64'sh7FFFFFFF || wy < -64'sh80000000) ? $urandom : 32'(wy);
				it.rect_width = it.rect_width * 65536 + $urandom_range(65535);
				it.rect_height = it.rect_height * 65536 + $urandom_range(65535);
			end
			// now and then a wide box, and now and then raw noise
			if ($urandom_range(99) < 2) begin
				it.rect_width = it.screen_relative ? 600 : 600 * 65536;
				it.rect_height = it.screen_relative ? 300 : 300 * 65536;
			end else if ($urandom_range(99) < 8) begin
				it.x_pos = $urandom;
				it.rect_width = $urandom;
			end
		end else if (pick < 90) begin
			it.action = (pick < 75) ? ACT_WR_PIX : ACT_RD_PIX;
			it.x_pos = ($urandom_range(99) < 90) ? $urandom_range(FW - 1) : $urandom;
			it.y_pos = ($urandom_range(99) < 90) ? $urandom_range(FH - 1) : $urandom;
		end else begin
			it.action = ACT_WR_LUT;
		end
		return it;
	endfunction

	// result side: random stalls, one long hold, field checks
	initial begin
		int       hold;
		bit       held;
		outcome_t e;
		hold = 0;
		held = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				n_results++;
				if (pending_q.size() == 0) begin
					$display("%0t unexpected result read_data=%h drew=%b", $time,
						res_ch.read_data, res_ch.drew_pixels);
					n_errors++;
				end else begin
					e = pending_q.pop_front();
					if (res_ch.read_data !== e.rd) begin
						$display("%0t read_data mismatch expected=%h actual=%h", $time,
							e.rd, res_ch.read_data);
						n_errors++;
					end
					if (res_ch.drew_pixels !== e.drew) begin
						$display("%0t drew_pixels mismatch expected=%b actual=%b", $time,
							e.drew, res_ch.drew_pixels);
						n_errors++;
					end
				end
			end
			// long hold-off so the block backs up into its input
			if (!held && n_results == 45) begin
				held = 1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (n_results >= 60 && n_results < 90) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= 22);
			end
		end
	end

	// directed table, then random phases
	initial begin
		item_t it;
		n_errors = 0;
		n_sent = 0;
		n_results = 0;
		arst_n = 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_CLIP_LEFT;
		wr_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_DRAW;
		cmd_ch.x_pos <= '0;
		cmd_ch.y_pos <= '0;
		cmd_ch.rect_width <= '0;
		cmd_ch.rect_height <= '0;
		cmd_ch.colour_rgb <= '0;
		cmd_ch.alpha <= '0;
		cmd_ch.ink_mode <= MODE_PLAIN;
		cmd_ch.screen_relative <= 1'b1;
		cmd_ch.pixel_data <= '0;
		cmd_ch.table_index <= '0;
		for (int i = 0; i < FW * FH; i++) pix_mem[i] = '0;
		for (int i = 0; i < 65536; i++) begin
			recol_mem[i] = '0;
			recol_known[i] = 0;
		end
		cl_left = 0;
		cl_right = 424;
		cl_top = 0;
		cl_bottom = 240;
		cam_x = 0;
		cam_y = 0;
		key_colour = '0;
		recol_on = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pixel access at the frame corners and just outside it
		rows.push_back('{mk(ACT_RD_PIX, 0, 0, 0, 0, 0, 0, MODE_PLAIN, 1, 0, 0), 1, '{16'h0, 0}});
		rows.push_back('{mk(ACT_WR_PIX, 0, 0, 0, 0, 0, 0, MODE_PLAIN, 1, 'hFFFF, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_WR_PIX, 511, 255, 0, 0, 0, 0, MODE_PLAIN, 1, 'h1234, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_RD_PIX, 511, 255, 0, 0, 0, 0, MODE_PLAIN, 1, 0, 0), 1,
			'{16'h1234, 0}});
		rows.push_back('{mk(ACT_WR_PIX, -1, 0, 0, 0, 0, 0, MODE_PLAIN, 1, 'hBEEF, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_RD_PIX, -1, 0, 0, 0, 0, 0, MODE_PLAIN, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_RD_PIX, 512, 255, 0, 0, 0, 0, MODE_PLAIN, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_WR_LUT, 0, 0, 0, 0, 0, 0, MODE_PLAIN, 1, 'hFFFF, 'hFFFF), 1,
			'{16'h0, 0}});
		// whole clip window in plain white
		rows.push_back('{mk(ACT_DRAW, 0, 0, 424, 240, 'hFFFFFF, 0, MODE_PLAIN, 1, 0, 0), 1,
			'{16'h0, 1}});
		// every ink
		rows.push_back('{mk(ACT_DRAW, 10, 10, 8, 4, 'h123456, 0, MODE_BLEND, 1, 0, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 10, 10, 8, 4, 'h123456, 0, MODE_ALPHA, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 12, 11, 5, 3, 'h00FF00, 128, MODE_ALPHA, 1, 0, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 14, 12, 4, 4, 'h000000, 511, MODE_ALPHA, 1, 0, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 12, 10, 6, 3, 'h808080, 400, MODE_ADD, 1, 0, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 12, 10, 6, 3, 'h808080, 0, MODE_ADD, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 9, 9, 7, 5, 'hFFFFFF, 100, MODE_SUB, 1, 0, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 9, 9, 7, 5, 'hFFFFFF, 0, MODE_SUB, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 0, 0, 4, 4, 'h0000FF, 0, MODE_RECOL, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 420, 236, 8, 8, 'hFF0000, 0, MODE_KEYED, 1, 0, 0), 0,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 8, 8, 12, 8, 'hFF0000, 0, MODE_UNKEYED, 1, 0, 0), 0,
			'{16'h0, 0}});
		// empty sizes and coordinate extremes
		rows.push_back('{mk(ACT_DRAW, 5, 5, -3, 4, 'hFFFFFF, 0, MODE_PLAIN, 1, 0, 0), 1,
			'{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 'h80000000, 0, 'h7FFFFFFF, 4, 'hFFFFFF, 0, MODE_PLAIN, 1,
			0, 0), 1, '{16'h0, 0}});
		rows.push_back('{mk(ACT_DRAW, 'h7FFFFFFF, 0, 1, 4, 'hFFFFFF, 0, MODE_PLAIN, 1, 0, 0),
			1, '{16'h0, 0}});
		// world units, negative fractional left edge
		rows.push_back('{mk(ACT_DRAW, -3 * 65536 + 'h8000, 'h28000, 6 * 65536, 'h3FFFF,
			'h3366CC, 0, MODE_PLAIN, 0, 0, 0), 0, '{16'h0, 0}});
		rows.push_back('{mk(ACT_RD_PIX, 12, 11, 0, 0, 0, 0, MODE_PLAIN, 1, 0, 0), 0,
			'{16'h0, 0}});
		foreach (rows[k]) send(rows[k].it, rows[k].typed, rows[k].want);

		// register phases, extremes first, then random
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_all(0, 512, 0, 256, 0, 0, 'hFFFF, 1);
				1: set_all(511, 512, 255, 256, -32768, 32767, $urandom, 0);
				2: set_all($urandom_range(100), $urandom_range(200, 1023),
					$urandom_range(60), $urandom_range(100, 511),
					$urandom_range(40) - 20, $urandom_range(40) - 20, $urandom, 1);
				default: set_all(300, 100, $urandom_range(255), $urandom_range(511),
					32767, -32768, 0, 1);
			endcase
			repeat (15) begin
				it = rand_cmd();
				if (it.action == ACT_DRAW && it.ink_mode == MODE_RECOL) fill_recol_gaps(it);
				send(it);
			end
		end
		// back to a roomy window with the table on for a last stretch
		set_all(0, 512, 0, 256, 3, -2, 'h0000, 1);
		repeat (15) begin
			it = rand_cmd();
			if (it.action == ACT_DRAW && it.ink_mode == MODE_RECOL) fill_recol_gaps(it);
			send(it);
		end

		cmd_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
